### rtl/core/w2s_pkg.sv
// ----------------------------------------------------------------------------
// w2s_pkg
// Types and constants shared by the world-to-screen projection block.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIM_W = 14;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd7;

  localparam logic [DIM_W-1:0] SCREEN_W_RESET = 14'd1920;
  localparam logic [DIM_W-1:0] SCREEN_H_RESET = 14'd1080;

  // Dot product sum width and divider widths.
  localparam int unsigned DOT_W = 64;
  localparam int unsigned QUO_W = 41;   // quotient clamped to 2^40
  localparam int unsigned NUM_W = 128;  // dividend bit count

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_item_t;

  // Per-lane divider state passed from cell to cell.
  typedef struct packed {
    logic [63:0]        rem;
    logic [NUM_W-1:0]   num;
    logic [QUO_W-1:0]   quo;
    logic               big;
    logic               neg;
  } div_lane_t;

  // Side data carried alongside the divider lanes.
  typedef struct packed {
    logic               valid;
    logic               visible;
    logic [63:0]        w;
    logic [DIM_W-1:0]   dim_x;
    logic [DIM_W-1:0]   dim_y;
  } div_side_t;

endpackage

### rtl/core/w2s_dot.sv
// ----------------------------------------------------------------------------
// w2s_dot
// Three pipelined dot products of a point with matrix rows x, y and w.
// ----------------------------------------------------------------------------
module w2s_dot #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  w2s_pkg::in_item_t       in_item,
  input  logic signed [31:0]      m [12],
  output logic                    out_valid,
  output logic signed [63:0]      cx,
  output logic signed [63:0]      cy,
  output logic signed [63:0]      cw
);

  logic               valid_p;
  logic signed [63:0] prod [9];
  logic signed [31:0] cst [3];
  logic signed [31:0] coord [3];

  assign coord[0] = in_item.world_x;
  assign coord[1] = in_item.world_y;
  assign coord[2] = in_item.world_z;

  // Stage 1: nine 32x32 products; stage 2 floors them with an arithmetic shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= 1'b0;
    end else begin
      valid_p <= in_valid;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r*3+c] <= 64'(m[r*4+c]) * 64'(coord[c]);
      end
      cst[r] <= m[r*4+3];
    end
  end

  // Stage 2: sum of floored products and the constant entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_p;
    end
    cx <= (prod[0] >>> FRAC_BITS) + (prod[1] >>> FRAC_BITS) + (prod[2] >>> FRAC_BITS)
          + 64'(cst[0]);
    cy <= (prod[3] >>> FRAC_BITS) + (prod[4] >>> FRAC_BITS) + (prod[5] >>> FRAC_BITS)
          + 64'(cst[1]);
    cw <= (prod[6] >>> FRAC_BITS) + (prod[7] >>> FRAC_BITS) + (prod[8] >>> FRAC_BITS)
          + 64'(cst[2]);
  end

endmodule

### rtl/core/w2s_div_cell.sv
// ----------------------------------------------------------------------------
// w2s_div_cell
// One restoring-division step for the x and y lanes, handing its state on.
// ----------------------------------------------------------------------------
module w2s_div_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  w2s_pkg::div_side_t    side_in,
  input  w2s_pkg::div_lane_t    lane_x_in,
  input  w2s_pkg::div_lane_t    lane_y_in,
  output w2s_pkg::div_side_t    side_out,
  output w2s_pkg::div_lane_t    lane_x_out,
  output w2s_pkg::div_lane_t    lane_y_out
);

  // Quotient bit written by this cell; cells at or above bit 40 only flag overflow.
  localparam int unsigned QBIT = (BIT_POS < 40) ? BIT_POS : 0;

  function automatic w2s_pkg::div_lane_t step(w2s_pkg::div_lane_t l, logic [63:0] w);
    w2s_pkg::div_lane_t o;
    logic [64:0]        r;
    o = l;
    r = {l.rem, l.num[BIT_POS]};
    if (r >= {1'b0, w}) begin
      r = r - {1'b0, w};
      if (BIT_POS >= 40) begin
        o.big = 1'b1;
      end else begin
        o.quo[QBIT] = 1'b1;
      end
    end
    o.rem = r[63:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.visible <= side_in.visible;
    side_out.w       <= side_in.w;
    side_out.dim_x   <= side_in.dim_x;
    side_out.dim_y   <= side_in.dim_y;
    lane_x_out       <= step(lane_x_in, side_in.w);
    lane_y_out       <= step(lane_y_in, side_in.w);
  end

endmodule

### rtl/core/world_to_screen_projection_top.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Perspective projection of world points to viewport pixels.
// ----------------------------------------------------------------------------
// Usage: pulse start with a point on item; busy is always low, so one point
// may enter every cycle. Each point gives exactly one result on result,
// marked by done for one cycle. Points come out in order.
// The pipeline: two dot product stages, one stage that scales the clip terms
// by the viewport size, a chain of 128 division cells (below bit 40 one
// quotient bit per cell, from bit 40 up an overflow flag) and one output
// stage. Throughput is one point per cycle; the chain holds up to 128 points.
// The matrix and viewport registers are written through cfg_we, cfg_idx and
// cfg_data; write them only while no point is in flight. Reset clears the
// matrix to zero, sets the viewport to 1920 x 1080 and drops all points in
// flight. The receiver cannot stall: done comes on a fixed schedule.
// Points whose clip w is below 0.01 come out with visible low and zero
// coordinates.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  w2s_pkg::in_item_t                     item,
  output logic                                  done,
  output w2s_pkg::out_item_t                    result,
  input  logic                                  cfg_we,
  input  logic [w2s_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [w2s_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned NCELL = w2s_pkg::NUM_W;
  localparam logic signed [63:0] THR = 64'(((64'd1 << FRAC_BITS) + 64'd99) / 64'd100);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [w2s_pkg::QUO_W-1:0] LIM = w2s_pkg::QUO_W'(64'd1 << 40);

  logic [63:0]                   mrow [6];
  logic [w2s_pkg::DIM_W-1:0]     screen_width;
  logic [w2s_pkg::DIM_W-1:0]     screen_height;
  logic signed [31:0]            m [12];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        mrow[i] <= '0;
      end
      screen_width  <= w2s_pkg::SCREEN_W_RESET;
      screen_height <= w2s_pkg::SCREEN_H_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        w2s_pkg::REG_ROW_X_FIRST:  mrow[0] <= cfg_data;
        w2s_pkg::REG_ROW_X_SECOND: mrow[1] <= cfg_data;
        w2s_pkg::REG_ROW_Y_FIRST:  mrow[2] <= cfg_data;
        w2s_pkg::REG_ROW_Y_SECOND: mrow[3] <= cfg_data;
        w2s_pkg::REG_ROW_W_FIRST:  mrow[4] <= cfg_data;
        w2s_pkg::REG_ROW_W_SECOND: mrow[5] <= cfg_data;
        w2s_pkg::REG_SCREEN_W:     screen_width <= cfg_data[w2s_pkg::DIM_W-1:0];
        w2s_pkg::REG_SCREEN_H:     screen_height <= cfg_data[w2s_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m[2*i]   = mrow[i][31:0];
      m[2*i+1] = mrow[i][63:32];
    end
  end

  logic               dot_valid;
  logic signed [63:0] cx, cy, cw;

  w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_item   (item),
    .m         (m),
    .out_valid (dot_valid),
    .cx        (cx),
    .cy        (cy),
    .cw        (cw)
  );

  // Scale stage: magnitude times the viewport size, two 32-bit halves each.
  logic [63:0] ax, ay;
  assign ax = cx[63] ? 64'(-cx) : 64'(cx);
  assign ay = cy[63] ? 64'(-cy) : 64'(cy);

  w2s_pkg::div_side_t side [NCELL+1];
  w2s_pkg::div_lane_t lx   [NCELL+1];
  w2s_pkg::div_lane_t ly   [NCELL+1];

  logic [46:0]  px_lo, px_hi, py_lo, py_hi;
  logic         s_neg_x, s_neg_y;
  w2s_pkg::div_side_t s_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_side.valid <= 1'b0;
    end else begin
      s_side.valid <= dot_valid;
    end
    s_side.visible <= !(cw < THR);
    s_side.w       <= cw;
    s_side.dim_x   <= screen_width;
    s_side.dim_y   <= screen_height;
    px_lo   <= 47'(ax[31:0]) * 47'(screen_width);
    px_hi   <= 47'(ax[63:32]) * 47'(screen_width);
    py_lo   <= 47'(ay[31:0]) * 47'(screen_height);
    py_hi   <= 47'(ay[63:32]) * 47'(screen_height);
    s_neg_x <= cx[63];
    s_neg_y <= cy[63];
  end

  logic [w2s_pkg::NUM_W-1:0] numx, numy;
  assign numx = ((128'(px_hi) << 32) + 128'(px_lo)) << (FRAC_BITS - 1);
  assign numy = ((128'(py_hi) << 32) + 128'(py_lo)) << (FRAC_BITS - 1);

  assign side[0] = s_side;
  assign lx[0]   = '{rem: '0, num: numx, quo: '0, big: 1'b0, neg: s_neg_x};
  assign ly[0]   = '{rem: '0, num: numy, quo: '0, big: 1'b0, neg: s_neg_y};

  // Cell k handles dividend bit NCELL-1-k, most significant first.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    w2s_div_cell #(.BIT_POS(NCELL - 1 - k)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .side_in    (side[k]),
      .lane_x_in  (lx[k]),
      .lane_y_in  (ly[k]),
      .side_out   (side[k+1]),
      .lane_x_out (lx[k+1]),
      .lane_y_out (ly[k+1])
    );
  end

  // Output stage: clamp, add the viewport offsets and saturate; hidden points read zero.
  w2s_pkg::div_side_t f_side;
  w2s_pkg::div_lane_t f_x, f_y;
  logic [w2s_pkg::QUO_W-1:0] qx, qy;
  logic signed [63:0]        tx, ty, sx, sy;

  assign f_side = side[NCELL];
  assign f_x    = lx[NCELL];
  assign f_y    = ly[NCELL];
  assign qx = (f_x.big || f_x.quo > LIM) ? LIM : f_x.quo;
  assign qy = (f_y.big || f_y.quo > LIM) ? LIM : f_y.quo;
  assign tx = f_x.neg ? -64'(qx) : 64'(qx);
  assign ty = f_y.neg ? -64'(qy) : 64'(qy);
  assign sx = 64'(f_side.dim_x) * HALF + tx + HALF;
  assign sy = 64'(f_side.dim_y) * HALF - ty - HALF;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_side.valid;
    end
    result.visible  <= f_side.visible;
    result.screen_x <= f_side.visible ? sat32(sx) : 32'sd0;
    result.screen_y <= f_side.visible ? sat32(sy) : 32'sd0;
  end

`ifndef ASSERT_OFF
  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.visible |-> result.screen_x == 0 && result.screen_y == 0)
    else $error("hidden point has coordinates");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    f_side.valid |=> done)
    else $error("result lost");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");
`endif

endmodule
